FILE: sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

    // Command passed from the front end to the compression engine.
    typedef enum logic [1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_FINAL1 = 2'd1,
        CMD_FINAL2 = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t         cmd;
        logic [511:0] block;
    } job_t;

    typedef enum logic [1:0] {
        ENG_IDLE  = 2'd0,
        ENG_ROUND = 2'd1,
        ENG_ADD   = 2'd2,
        ENG_EMIT  = 2'd3
    } eng_state_t;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam int         LENGTH_AT = 56;

    localparam logic [255:0] INIT_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sha_front.sv
`default_nettype none
// Collects bytes into a block and builds padded blocks at end of message.
module sha_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          byte_valid,
    input  wire logic          end_of_message,
    output logic               job_valid,
    input  wire logic          job_ready,
    output sha_pkg::job_t      job
);

    logic [511:0] blk_reg, blk_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  total_reg, total_next;
    logic         pend_reg, pend_next;
    logic [511:0] pend_blk_reg, pend_blk_next;
    logic         job_valid_reg, job_valid_next;
    sha_pkg::job_t job_reg, job_next;

    // Space for a whole message close: one job slot plus one pending slot.
    assign in_ready  = !job_valid_reg && !pend_reg;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_comb
    begin
        logic [511:0] b;
        logic [6:0]   f;
        logic [63:0]  bits;
        b = blk_reg;
        f = {1'b0, fill_reg};
        blk_next       = blk_reg;
        fill_next      = fill_reg;
        total_next     = total_reg;
        pend_next      = pend_reg;
        pend_blk_next  = pend_blk_reg;
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        bits = 64'd0;

        // Hand the job off, then promote a pending final block.
        if (job_valid_reg && job_ready)
        begin
            job_valid_next = pend_reg;
            job_next.cmd   = sha_pkg::CMD_FINAL2;
            job_next.block = pend_blk_reg;
            pend_next      = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            if (byte_valid)
            begin
                b[511 - 8*fill_reg -: 8] = data_byte;
                f = f + 7'd1;
                total_next = total_reg + 64'd1;
            end
            bits = total_next << 3;
            if (f == 7'd64)
            begin
                job_valid_next = 1'b1;
                job_next.cmd   = sha_pkg::CMD_BLOCK;
                job_next.block = b;
                f = 7'd0;
            end
            if (end_of_message)
            begin
                // Mark byte, then zeros behind it.
                b[511 - 8*f[5:0] -: 8] = sha_pkg::PAD_MARK;
                for (int i = 0; i < 64; i++)
                    if (i > f) b[511 - 8*i -: 8] = 8'h00;
                if (f + 7'd1 > 7'(sha_pkg::LENGTH_AT))
                begin
                    if (job_valid_next)
                    begin
                        // A full block is already queued; should not occur.
                        pend_next = 1'b1;
                    end
                    job_valid_next = 1'b1;
                    job_next.cmd   = sha_pkg::CMD_FINAL1;
                    job_next.block = b;
                    pend_next      = 1'b1;
                    pend_blk_next  = {448'd0, bits};
                end
                else if (job_valid_next)
                begin
                    // Full block then final block.
                    pend_next     = 1'b1;
                    pend_blk_next = {b[511:64], bits};
                end
                else
                begin
                    job_valid_next = 1'b1;
                    job_next.cmd   = sha_pkg::CMD_FINAL2;
                    job_next.block = {b[511:64], bits};
                end
                f = 7'd0;
                total_next = 64'd0;
            end
            blk_next  = b;
            fill_next = f[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg      <= blk_next;
        pend_blk_reg <= pend_blk_next;
        job_reg      <= job_next;
    end

endmodule
`default_nettype wire

FILE: sv/sha_engine.sv
`default_nettype none
// Runs 64 compression rounds, one per cycle, and emits the digest after a final block.
module sha_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    output logic               job_ready,
    input  wire sha_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [31:0]        digest_word,
    output logic [2:0]         word_index,
    output logic               last_word
);

    sha_pkg::eng_state_t state_reg, state_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [511:0] w_reg, w_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [2:0]   idx_reg, idx_next;
    logic         fin_reg, fin_next;

    assign job_ready   = (state_reg == sha_pkg::ENG_IDLE);
    assign out_valid   = (state_reg == sha_pkg::ENG_EMIT);
    assign digest_word = h_reg[255 - 32*idx_reg -: 32];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'd7);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb
    begin
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, x, y, wn;
        {a, b, c, d, e, f, g, h} = v_reg;
        state_next = state_reg;
        h_next   = h_reg;
        v_next   = v_reg;
        w_next   = w_reg;
        rnd_next = rnd_reg;
        idx_next = idx_reg;
        fin_next = fin_reg;
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + sha_pkg::round_k(rnd_reg) + w_reg[511:480];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        x  = w_reg[479:448];
        y  = w_reg[63:32];
        wn = w_reg[511:480] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w_reg[223:192]
             + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
        case (state_reg)
            sha_pkg::ENG_IDLE:
            begin
                if (job_valid)
                begin
                    w_next   = job.block;
                    v_next   = h_reg;
                    rnd_next = 6'd0;
                    fin_next = (job.cmd == sha_pkg::CMD_FINAL2);
                    state_next = sha_pkg::ENG_ROUND;
                end
            end
            sha_pkg::ENG_ROUND:
            begin
                v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next = {w_reg[479:0], wn};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = sha_pkg::ENG_ADD;
            end
            sha_pkg::ENG_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[32*i +: 32] = h_reg[32*i +: 32] + v_reg[32*i +: 32];
                idx_next = 3'd0;
                state_next = fin_reg ? sha_pkg::ENG_EMIT : sha_pkg::ENG_IDLE;
            end
            sha_pkg::ENG_EMIT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        h_next = sha_pkg::INIT_HASH;
                        state_next = sha_pkg::ENG_IDLE;
                    end
                end
            end
            default: state_next = sha_pkg::ENG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ENG_IDLE;
            h_reg     <= sha_pkg::INIT_HASH;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end

endmodule
`default_nettype wire

FILE: sv/sha256_stream_hasher_unit.sv
`default_nettype none
// Channel | Dir | tdata (low bit up)                 | tuser / tlast
// s_axis  | in  | [7:0] data_byte, [8] byte_valid    | tlast end_of_message
// m_axis  | out | [31:0] digest_word                 | tuser word_index, tlast last_word
// A byte is taken each cycle that s_axis_tready is high; a full block runs through the
// one-round-per-cycle compression loop, so the sustained rate is near one byte a cycle.
// A close takes one or two compressions, then eight digest beats.
// Reset is asynchronous; afterwards the hash holds the initial words.
// Input stalls while a block job is queued; output stalls hold the engine.
module sha256_stream_hasher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // data_byte, byte_valid, zero fill
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // digest_word
    output logic [2:0]       m_axis_tuser,   // word_index
    output logic             m_axis_tlast
);

    logic          job_valid, job_ready;
    sha_pkg::job_t job;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata[7:0]), .byte_valid(s_axis_tdata[8]),
        .end_of_message(s_axis_tlast),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    sha_engine u_engine (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .digest_word(m_axis_tdata), .word_index(m_axis_tuser),
        .last_word(m_axis_tlast)
    );

endmodule
`default_nettype wire
